>>> hw/rtl/oidd_pkg.sv
// ----------------------------------------------------------------------------
// oidd_pkg: shared constants and helpers for the OID dotted-decimal renderer
// Character codes, queue sizing and small constant divisions used by the
// front end (octet intake) and the back end (decimal emission).
// ----------------------------------------------------------------------------
package oidd_pkg;

    // Default accumulator width, legal range 32..64
    localparam int ACC_WIDTH_DEF = 64;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Leading zero bits skipped per cycle before the first one bit
    localparam int SKIP_BITS = 8;

    // Emitted characters
    localparam logic [5:0] CH_DOT  = 6'd46;
    localparam logic [5:0] CH_ZERO = 6'd48;

    // Octet layout
    localparam logic [7:0] ARC_MORE = 8'h80;

    // Packing of a first-octet job in the value field
    localparam int REM_BITS = 6;
    localparam int QUO_BITS = 3;

    // Quotient of an octet by 40 (0..6)
    function automatic logic [2:0] div40(input logic [7:0] octet);
        logic [2:0] q;
        q = 3'd0;
        if (octet >= 8'd40)  q = 3'd1;
        if (octet >= 8'd80)  q = 3'd2;
        if (octet >= 8'd120) q = 3'd3;
        if (octet >= 8'd160) q = 3'd4;
        if (octet >= 8'd200) q = 3'd5;
        if (octet >= 8'd240) q = 3'd6;
        return q;
    endfunction

    // Tens digit of a value below 40
    function automatic logic [1:0] tens40(input logic [5:0] r);
        logic [1:0] t;
        t = 2'd0;
        if (r >= 6'd10) t = 2'd1;
        if (r >= 6'd20) t = 2'd2;
        if (r >= 6'd30) t = 2'd3;
        return t;
    endfunction

endpackage

>>> hw/rtl/oidd_front.sv
// ----------------------------------------------------------------------------
// oidd_front: octet intake and arc assembly
// Accepts one octet per beat, splits a first octet into its two arcs, shifts
// later octets into the arc accumulator, pushes finished arcs as jobs and drops octets on overflow.
// ----------------------------------------------------------------------------
module oidd_front
    import oidd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_octet,
    input  logic                 in_first,
    input  logic                 queue_full,
    output logic                 push,
    output logic                 push_first,
    output logic [ACC_WIDTH-1:0] push_value
);

    logic [ACC_WIDTH-1:0] acc_reg;
    logic [ACC_WIDTH-1:0] acc_next;
    logic [ACC_WIDTH-1:0] acc_shift;
    logic                 accept;
    logic                 over_limit;
    logic [2:0]           quo;
    logic [7:0]           rem8;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Accumulator above the limit when any of its top seven bits is set
    assign over_limit = (acc_reg[ACC_WIDTH-1 -: 7] != 7'd0);
    assign acc_shift  = {acc_reg[ACC_WIDTH-8:0], in_octet[6:0]};

    // Split a first octet into octet / 40 and octet % 40
    assign quo  = div40(in_octet);
    assign rem8 = in_octet - 8'(quo * 8'd40);

    // Classify the beat and build the job
    always_comb
    begin
        acc_next   = acc_reg;
        push       = 1'b0;
        push_first = 1'b0;
        push_value = '0;
        if (accept)
        begin
            if (in_first)
            begin
                acc_next   = '0;
                push       = 1'b1;
                push_first = 1'b1;
                push_value[REM_BITS+QUO_BITS-1:0] = {quo, rem8[REM_BITS-1:0]};
            end
            else if (over_limit)
            begin
                acc_next = '0;
            end
            else if ((in_octet & ARC_MORE) == 8'd0)
            begin
                acc_next   = '0;
                push       = 1'b1;
                push_value = acc_shift;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> hw/rtl/oidd_queue.sv
// ----------------------------------------------------------------------------
// oidd_queue: short job queue
// Holds finished jobs between front and back so that each side can stall
// on its own. Head entry is visible without a pop.
// ----------------------------------------------------------------------------
module oidd_queue
    import oidd_pkg::*;
#(
    parameter int DW = ACC_WIDTH_DEF + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          empty,
    output logic          full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign empty     = (count_reg == CW'(0));
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign head_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

>>> hw/rtl/oidd_back.sv
// ----------------------------------------------------------------------------
// oidd_back: decimal conversion and character emission
// Pops one job at a time, converts an arc to BCD with a shift-and-add-3
// loop (one bit a cycle, leading zero bytes skipped), and emits a head digit for a first-octet job,
// then the dot and the digits most significant first through a registered output beat.
// ----------------------------------------------------------------------------
module oidd_back
    import oidd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_avail,
    input  logic                 job_first,
    input  logic [ACC_WIDTH-1:0] job_value,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           out_char,
    output logic                 out_last
);

    // Decimal digits needed for the widest accumulator value
    localparam int NDIG = (ACC_WIDTH * 30103) / 100000 + 1;
    localparam int IW   = $clog2(NDIG);
    localparam int LW   = $clog2(NDIG + 1);
    localparam int CW   = $clog2(ACC_WIDTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_CONV = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [ACC_WIDTH-1:0]       bin_reg;
    logic [ACC_WIDTH-1:0]       bin_next;
    logic [NDIG-1:0][3:0]       bcd_reg;
    logic [NDIG-1:0][3:0]       bcd_next;
    logic [NDIG-1:0][3:0]       bcd_adj;
    logic [NDIG-1:0][3:0]       bcd_step;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cnt_next;
    logic [LW-1:0]              len_reg;
    logic [LW-1:0]              len_next;
    logic [IW-1:0]              idx_reg;
    logic [IW-1:0]              idx_next;
    logic                       seen_reg;
    logic                       seen_next;
    logic [2:0]                 head_reg;
    logic [2:0]                 head_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [5:0]                 out_char_reg;
    logic [5:0]                 out_char_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic                       load_ok;
    logic                       emit;
    logic                       skip;
    logic [5:0]                 rem;
    logic [1:0]                 rem_tens;
    logic [3:0]                 rem_ones;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    assign load_ok = !out_valid_reg || out_ready;

    // Split the remainder of a first octet into two digits
    assign rem      = job_value[REM_BITS-1:0];
    assign rem_tens = tens40(rem);
    assign rem_ones = 4'(rem - 6'(rem_tens * 6'd10));

    // One double-dabble step: adjust digits of 5 and up, then shift in a bit
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_step[0] = {bcd_adj[0][2:0], bin_reg[ACC_WIDTH-1]};
        for (int i = 1; i < NDIG; i++)
        begin
            bcd_step[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
        end
    end

    // Skip a zero byte while no one bit has been shifted into the BCD yet
    assign skip = !seen_reg && (bin_reg[ACC_WIDTH-1 -: SKIP_BITS] == '0) &&
                  (cnt_reg >= CW'(SKIP_BITS));

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        head_next      = head_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_avail)
                begin
                    pop = 1'b1;
                    if (job_first)
                    begin
                        bcd_next    = '0;
                        bcd_next[0] = rem_ones;
                        bcd_next[1] = {2'b00, rem_tens};
                        len_next    = (rem_tens != 2'd0) ? LW'(2) : LW'(1);
                        head_next   = job_value[REM_BITS+QUO_BITS-1:REM_BITS];
                        state_next  = S_HEAD;
                    end
                    else
                    begin
                        bin_next   = job_value;
                        bcd_next   = '0;
                        cnt_next   = CW'(ACC_WIDTH);
                        len_next   = LW'(1);
                        seen_next  = 1'b0;
                        state_next = S_CONV;
                    end
                end
            end
            S_HEAD:
            begin
                if (load_ok)
                begin
                    emit          = 1'b1;
                    out_char_next = CH_ZERO + {3'b000, head_reg};
                    out_last_next = 1'b0;
                    state_next    = S_DOT;
                end
            end
            S_CONV:
            begin
                if (skip)
                begin
                    bin_next = bin_reg << SKIP_BITS;
                    cnt_next = cnt_reg - CW'(SKIP_BITS);
                end
                else
                begin
                    bcd_next  = bcd_step;
                    bin_next  = bin_reg << 1;
                    cnt_next  = cnt_reg - CW'(1);
                    seen_next = seen_reg || bin_reg[ACC_WIDTH-1];
                    // Digit count grows by at most one per step
                    if (len_reg < LW'(NDIG))
                    begin
                        if (bcd_step[len_reg[IW-1:0]] != 4'd0)
                        begin
                            len_next = len_reg + LW'(1);
                        end
                    end
                end
                if (cnt_next == '0)
                begin
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                if (load_ok)
                begin
                    emit          = 1'b1;
                    out_char_next = CH_DOT;
                    out_last_next = 1'b0;
                    idx_next      = IW'(len_reg - LW'(1));
                    state_next    = S_DIG;
                end
            end
            S_DIG:
            begin
                if (load_ok)
                begin
                    emit          = 1'b1;
                    out_char_next = CH_ZERO + {2'b00, bcd_reg[idx_reg]};
                    out_last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output beat until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        seen_reg     <= seen_next;
        head_reg     <= head_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> (cnt_reg != '0))
        else $error("conversion running with no bits left");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIG) |-> (LW'(idx_reg) < len_reg))
        else $error("digit index beyond the digit count");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_last_next) |=> (state_reg == S_IDLE && out_valid_reg && out_last_reg))
        else $error("final character did not end the job");

endmodule

>>> hw/rtl/oid_to_dotted_decimal.sv
// ----------------------------------------------------------------------------
// oid_to_dotted_decimal: object identifier to dotted-decimal text
// Renders the content octets of a DER object identifier as ASCII text.
//
// Input stream: one content octet per beat in s_axis_tdata, s_axis_tuser
// high on the first octet of an identifier. Output stream: one character
// per beat, '.' or a digit in m_axis_tdata[5:0]; m_axis_tlast marks the last
// character caused by one input octet. Continuation octets and dropped
// overflow octets produce no beat.
// Throughput: one input octet a cycle into a two-entry job queue while the
// queue is not full. The back end pops one job at a time and finishes it
// before the next: a first octet is popped, then its head digit, the dot and
// its remainder digits are emitted. A finished arc is popped, converted to
// BCD bit by bit by the serial shift-and-add-3 converter (leading zero bytes
// skipped a byte at a time), then its dot and digits are emitted.
// Reset clears the accumulator, empties the queue and drops any pending
// output. A stalled receiver holds the output beat; the back end waits and,
// once the queue is full, s_axis_tready goes low.
// ----------------------------------------------------------------------------
module oid_to_dotted_decimal
    import oidd_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] oid_byte
    input  logic       s_axis_tuser,   // [0] first_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] out_char, [7:6] zero
    output logic       m_axis_tlast
);

    logic                 queue_full;
    logic                 queue_empty;
    logic                 push;
    logic                 push_first;
    logic [ACC_WIDTH-1:0] push_value;
    logic                 pop;
    logic [ACC_WIDTH:0]   head_data;
    logic [5:0]           out_char;

    // Accept and classify octets
    oidd_front #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_octet   (s_axis_tdata),
        .in_first   (s_axis_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_first (push_first),
        .push_value (push_value)
    );

    // Buffer jobs between front and back
    oidd_queue #(
        .DW (ACC_WIDTH + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_first, push_value}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Convert and emit characters
    oidd_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!queue_empty),
        .job_first (head_data[ACC_WIDTH]),
        .job_value (head_data[ACC_WIDTH-1:0]),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_char};

endmodule
